### rtl/aigsh_pkg.sv
`default_nettype none
package aigsh_pkg;

    // Table geometry defaults
    localparam int BucketsDefault = 1021;
    localparam int NodesDefault   = 1024;

    // Fixed field widths
    localparam int ID_W   = 10;
    localparam int KEY_W  = 23;
    localparam int HASH_W = 23;
    localparam int CNT_W  = 11;

    // Hash multipliers and mixing constants
    localparam int HASH_X  = 1699;
    localparam int HASH_L  = 7937;
    localparam int HASH_R  = 2971;
    localparam int HASH_LI = 911;
    localparam int HASH_RI = 353;

    // Cycles from a stable key to a valid bucket index
    localparam int HASH_LAT = 4;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISS       = 3'd1,
        ST_DUP_KEY    = 3'd2,
        ST_ID_PRESENT = 3'd3,
        ST_BAD_ORDER  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDID,
        S_CHK,
        S_HASH,
        S_RDH,
        S_HEAD,
        S_WALK,
        S_APP1,
        S_APP2,
        S_DELLINK,
        S_DELFIN,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    clr;
        logic    latch;
        logic    key_stored;
        logic    walk_head;
        logic    walk_next;
        logic    wr_head_id;
        logic    wr_head_del;
        logic    wr_next_tail;
        logic    wr_next_del;
        logic    app_fin;
        logic    del_fin;
        logic    set_res;
        t_status res;
        logic    res_match;
        logic    load_out;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_action action;
        logic    bad_order;
        logic    id_oob;
        logic    ref_miss;
        logic    present;
        logic    head_end;
        logic    head_tgt;
        logic    next_end;
        logic    next_tgt;
        logic    key_match;
        logic    clr_last;
    } t_dp_stat;

    function automatic logic [KEY_W-1:0] make_key(
        input logic            x,
        input logic [ID_W-1:0] l,
        input logic            li,
        input logic [ID_W-1:0] r,
        input logic            ri
    );
        make_key = {x, l, li, r, ri};
    endfunction

endpackage
`default_nettype wire

### rtl/aig_structural_hash_table_core.sv
`default_nettype none
// Structural hash table of AND/XOR graph nodes with lookup, insert and delete.
// After reset the block sweeps its bucket-head and presence memories, one entry
// a cycle, over max(BUCKETS, NODES) entries (1024 by default) before it takes the
// first item; configuration writes are taken at any time. An item that fails an
// early check (bad fanin order, reference miss, id out of range or already
// present, delete of an absent id, unknown action) gets its result straight from
// the check. Any other item runs a four-stage bucket hash (multiply by a
// reciprocal of BUCKETS) followed by one node-memory read per chain node visited.
// One item is worked on at a time; the next item is taken while the previous
// result waits in the output register.
module aig_structural_hash_table_core #(
    parameter int BUCKETS = aigsh_pkg::BucketsDefault,
    parameter int NODES   = aigsh_pkg::NodesDefault
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_action,
    input  wire logic [aigsh_pkg::ID_W-1:0]  i_node_id,
    input  wire logic                        i_is_xor,
    input  wire logic [aigsh_pkg::ID_W-1:0]  i_left_id,
    input  wire logic                        i_left_inverted,
    input  wire logic [aigsh_pkg::ID_W-1:0]  i_right_id,
    input  wire logic                        i_right_inverted,
    input  wire logic                        i_left_referenced,
    input  wire logic                        i_right_referenced,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [2:0]                       o_status,
    output logic [aigsh_pkg::ID_W-1:0]       o_match_id,
    output logic [aigsh_pkg::CNT_W-1:0]      o_entry_count,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_ref_check_enable
);
    import aigsh_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    aigsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    aigsh_dp #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_stat                 (stat),
        .i_cfg_we               (i_cfg_valid & o_cfg_ready),
        .i_cfg_ref_check_enable (i_cfg_ref_check_enable),
        .i_action               (i_action),
        .i_node_id              (i_node_id),
        .i_is_xor               (i_is_xor),
        .i_left_id              (i_left_id),
        .i_left_inverted        (i_left_inverted),
        .i_right_id             (i_right_id),
        .i_right_inverted       (i_right_inverted),
        .i_left_referenced      (i_left_referenced),
        .i_right_referenced     (i_right_referenced),
        .o_status               (o_status),
        .o_match_id             (o_match_id),
        .o_entry_count          (o_entry_count)
    );

endmodule
`default_nettype wire

### rtl/aigsh_hash.sv
`default_nettype none
module aigsh_hash #(
    parameter int BUCKETS = aigsh_pkg::BucketsDefault
) (
    input  wire logic                          i_clk,
    input  wire logic [aigsh_pkg::KEY_W-1:0]   i_key,
    output logic      [$clog2(BUCKETS)-1:0]    o_bucket
);
    import aigsh_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int SH = HASH_W + BW;
    localparam int MW = HASH_W + 2;
    localparam int PW = HASH_W + MW;
    localparam logic [63:0] MULT = (64'd1 << SH) / 64'(BUCKETS);

    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] r_h;
    logic [HASH_W-1:0] r_h2;
    logic [HASH_W-1:0] r_q;
    logic [BW:0]       r_rem;
    logic [BW-1:0]     r_bucket;
    logic [PW-1:0]     prod;
    logic [PW-1:0]     prod_sh;
    logic [HASH_W+BW-1:0] qb_full;
    logic [HASH_W-1:0] rem_full;
    logic [BW:0]       rem_sub;

    // Mix the key fields
    always_comb begin
        h = (i_key[22] ? HASH_W'(HASH_X) : '0)
          ^ (HASH_W'(i_key[21:12]) * HASH_W'(HASH_L))
          ^ (HASH_W'(i_key[10:1]) * HASH_W'(HASH_R))
          ^ (i_key[11] ? HASH_W'(HASH_LI) : '0)
          ^ (i_key[0] ? HASH_W'(HASH_RI) : '0);
    end

    // Estimate quotient by reciprocal, then remainder and one correction
    assign prod     = PW'(r_h) * PW'(MULT[MW-1:0]);
    assign prod_sh  = prod >> SH;
    assign qb_full  = (HASH_W+BW)'(r_q) * (HASH_W+BW)'(BUCKETS);
    assign rem_full = r_h2 - qb_full[HASH_W-1:0];
    assign rem_sub  = r_rem - (BW+1)'(BUCKETS);

    always_ff @(posedge i_clk) begin
        r_h      <= h;
        r_h2     <= r_h;
        r_q      <= prod_sh[HASH_W-1:0];
        r_rem    <= rem_full[BW:0];
        r_bucket <= (r_rem >= (BW+1)'(BUCKETS)) ? rem_sub[BW-1:0] : r_rem[BW-1:0];
    end

    assign o_bucket = r_bucket;

endmodule
`default_nettype wire

### rtl/aigsh_dp.sv
`default_nettype none
module aigsh_dp #(
    parameter int BUCKETS = aigsh_pkg::BucketsDefault,
    parameter int NODES   = aigsh_pkg::NodesDefault
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire aigsh_pkg::t_dp_cmd          i_cmd,
    output aigsh_pkg::t_dp_stat              o_stat,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_ref_check_enable,
    input  wire logic [1:0]                  i_action,
    input  wire logic [aigsh_pkg::ID_W-1:0]  i_node_id,
    input  wire logic                        i_is_xor,
    input  wire logic [aigsh_pkg::ID_W-1:0]  i_left_id,
    input  wire logic                        i_left_inverted,
    input  wire logic [aigsh_pkg::ID_W-1:0]  i_right_id,
    input  wire logic                        i_right_inverted,
    input  wire logic                        i_left_referenced,
    input  wire logic                        i_right_referenced,
    output logic [2:0]                       o_status,
    output logic [aigsh_pkg::ID_W-1:0]       o_match_id,
    output logic [aigsh_pkg::CNT_W-1:0]      o_entry_count
);
    import aigsh_pkg::*;

    localparam int BW    = $clog2(BUCKETS);
    localparam int IW    = $clog2(NODES);
    localparam int LW    = $clog2(NODES + 1);
    localparam int CLR_N = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLW   = $clog2(CLR_N + 1);
    localparam logic [LW-1:0] NODES_L = LW'(NODES);

    // Memories
    logic [LW-1:0]    mem_head [BUCKETS];
    logic [LW-1:0]    mem_next [NODES];
    logic [KEY_W-1:0] mem_key  [NODES];
    logic             mem_pres [NODES];

    logic [LW-1:0]    head_q;
    logic [LW-1:0]    next_q;
    logic [KEY_W-1:0] key_q;
    logic             pres_q;

    // Item registers
    t_action          r_action;
    logic [ID_W-1:0]  r_id;
    logic [KEY_W-1:0] r_key;
    logic             r_bad_order;
    logic             r_ref_ok;
    logic             r_refchk;
    logic [LW-1:0]    r_link;
    logic [LW-1:0]    r_delnext;
    logic [CLW-1:0]   r_clr;
    logic [LW-1:0]    r_count;
    t_status          r_res_status;
    logic [ID_W-1:0]  r_res_match;
    t_status          r_out_status;
    logic [ID_W-1:0]  r_out_match;
    logic [CNT_W-1:0] r_out_count;

    logic [BW-1:0]    bucket;
    logic [IW+ID_W-1:0] id_ext;
    logic [IW-1:0]    id_idx;
    logic [LW-1:0]    id_link;
    logic [LW-1:0]    link_m1;
    logic [LW-1:0]    head_m1;
    logic [LW-1:0]    next_m1;
    logic [IW-1:0]    rd_addr;
    logic             nx_we;
    logic [IW-1:0]    nx_addr;
    logic [LW-1:0]    nx_data;
    logic [IW+ID_W-1:0] match_ext;
    logic [LW+CNT_W-1:0] cnt_ext;

    aigsh_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_key    (r_key),
        .o_bucket (bucket)
    );

    assign id_ext  = {{IW{1'b0}}, r_id};
    assign id_idx  = id_ext[IW-1:0];
    assign id_link = LW'(id_ext) + LW'(1);
    assign link_m1 = r_link - LW'(1);
    assign head_m1 = head_q - LW'(1);
    assign next_m1 = next_q - LW'(1);

    // Pick the node read address
    always_comb begin
        rd_addr = id_idx;
        if (i_cmd.walk_head) begin
            rd_addr = head_m1[IW-1:0];
        end else if (i_cmd.walk_next) begin
            rd_addr = next_m1[IW-1:0];
        end
    end

    // Next-link write port
    always_comb begin
        nx_we   = i_cmd.wr_next_tail | i_cmd.wr_next_del | i_cmd.app_fin | i_cmd.del_fin;
        nx_addr = (i_cmd.wr_next_tail | i_cmd.wr_next_del) ? link_m1[IW-1:0] : id_idx;
        nx_data = i_cmd.wr_next_tail ? id_link :
                  i_cmd.wr_next_del  ? r_delnext : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && r_clr < CLW'(BUCKETS)) begin
            mem_head[r_clr[BW-1:0]] <= '0;
        end else if (i_cmd.wr_head_id) begin
            mem_head[bucket] <= id_link;
        end else if (i_cmd.wr_head_del) begin
            mem_head[bucket] <= r_delnext;
        end
        head_q <= mem_head[bucket];
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            mem_next[nx_addr] <= nx_data;
        end
        next_q <= mem_next[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.app_fin) begin
            mem_key[id_idx] <= r_key;
        end
        key_q <= mem_key[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && r_clr < CLW'(NODES)) begin
            mem_pres[r_clr[IW-1:0]] <= 1'b0;
        end else if (i_cmd.app_fin) begin
            mem_pres[id_idx] <= 1'b1;
        end else if (i_cmd.del_fin) begin
            mem_pres[id_idx] <= 1'b0;
        end
        pres_q <= mem_pres[rd_addr];
    end

    // Control registers: clear sweep, count, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_count  <= '0;
            r_refchk <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + CLW'(1);
            end
            if (i_cmd.app_fin) begin
                r_count <= r_count + LW'(1);
            end else if (i_cmd.del_fin && r_count != '0) begin
                r_count <= r_count - LW'(1);
            end
            if (i_cfg_we) begin
                r_refchk <= i_cfg_ref_check_enable;
            end
        end
    end

    // Item, walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action    <= t_action'(i_action);
            r_id        <= i_node_id;
            r_key       <= make_key(i_is_xor, i_left_id, i_left_inverted,
                                    i_right_id, i_right_inverted);
            r_bad_order <= (i_left_id >= i_right_id);
            r_ref_ok    <= i_left_referenced & i_right_referenced;
        end else if (i_cmd.key_stored) begin
            r_key     <= key_q;
            r_delnext <= next_q;
        end
        if (i_cmd.walk_head) begin
            r_link <= head_q;
        end else if (i_cmd.walk_next) begin
            r_link <= next_q;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res;
            r_res_match  <= i_cmd.res_match ? match_ext[ID_W-1:0] : '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_match  <= r_res_match;
            r_out_count  <= cnt_ext[CNT_W-1:0];
        end
    end

    assign match_ext = {{ID_W{1'b0}}, link_m1[IW-1:0]};
    assign cnt_ext   = {{CNT_W{1'b0}}, r_count};

    // Status flags
    always_comb begin
        o_stat.action    = r_action;
        o_stat.bad_order = r_bad_order;
        o_stat.id_oob    = (LW'(id_ext) >= NODES_L) || (id_ext >= (IW+ID_W)'(NODES));
        o_stat.ref_miss  = r_refchk & ~r_ref_ok;
        o_stat.present   = pres_q;
        o_stat.head_end  = (head_q == '0) || (head_q > NODES_L);
        o_stat.head_tgt  = (head_q == id_link);
        o_stat.next_end  = (next_q == '0) || (next_q > NODES_L);
        o_stat.next_tgt  = (next_q == id_link);
        o_stat.key_match = (key_q == r_key);
        o_stat.clr_last  = (r_clr == CLW'(CLR_N - 1));
    end

    assign o_status      = r_out_status;
    assign o_match_id    = r_out_match;
    assign o_entry_count = r_out_count;

endmodule
`default_nettype wire

### rtl/aigsh_ctrl.sv
`default_nettype none
module aigsh_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire logic                i_stall,
    input  wire aigsh_pkg::t_dp_stat i_stat,
    output aigsh_pkg::t_dp_cmd       o_cmd
);
    import aigsh_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       r_ovalid;
    logic       n_ovalid;
    logic       out_free;

    assign out_free = ~r_ovalid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_cmd.res = ST_MISS;
        n_ovalid = r_ovalid & i_stall;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RDID;
                end
            end
            S_RDID: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_cnt   = '0;
                n_state = S_DONE;
                o_cmd.set_res = 1'b1;
                case (i_stat.action)
                    ACT_LOOKUP: begin
                        if (i_stat.bad_order) begin
                            o_cmd.res = ST_BAD_ORDER;
                        end else if (!i_stat.ref_miss) begin
                            o_cmd.set_res = 1'b0;
                            n_state       = S_HASH;
                        end
                    end
                    ACT_INSERT: begin
                        if (i_stat.bad_order) begin
                            o_cmd.res = ST_BAD_ORDER;
                        end else if (i_stat.id_oob || i_stat.present) begin
                            o_cmd.res = ST_ID_PRESENT;
                        end else begin
                            o_cmd.set_res = 1'b0;
                            n_state       = S_HASH;
                        end
                    end
                    ACT_DELETE: begin
                        if (!i_stat.id_oob && i_stat.present) begin
                            o_cmd.set_res    = 1'b0;
                            o_cmd.key_stored = 1'b1;
                            n_state          = S_HASH;
                        end
                    end
                    default: begin
                        o_cmd.res = ST_MISS;
                    end
                endcase
            end
            S_HASH: begin
                if (r_cnt == 2'(HASH_LAT - 1)) begin
                    n_state = S_RDH;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_RDH: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                case (i_stat.action)
                    ACT_LOOKUP: begin
                        if (i_stat.head_end) begin
                            o_cmd.set_res = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.walk_head = 1'b1;
                            n_state         = S_WALK;
                        end
                    end
                    ACT_INSERT: begin
                        if (i_stat.head_end) begin
                            o_cmd.wr_head_id = 1'b1;
                            n_state          = S_APP2;
                        end else begin
                            o_cmd.walk_head = 1'b1;
                            n_state         = S_WALK;
                        end
                    end
                    default: begin
                        if (i_stat.head_tgt) begin
                            o_cmd.wr_head_del = 1'b1;
                            n_state           = S_DELFIN;
                        end else if (i_stat.head_end) begin
                            n_state = S_DELFIN;
                        end else begin
                            o_cmd.walk_head = 1'b1;
                            n_state         = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK: begin
                case (i_stat.action)
                    ACT_LOOKUP: begin
                        if (i_stat.key_match) begin
                            o_cmd.set_res   = 1'b1;
                            o_cmd.res       = ST_OK;
                            o_cmd.res_match = 1'b1;
                            n_state         = S_DONE;
                        end else if (i_stat.next_end) begin
                            o_cmd.set_res = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.walk_next = 1'b1;
                        end
                    end
                    ACT_INSERT: begin
                        if (i_stat.key_match) begin
                            o_cmd.set_res = 1'b1;
                            o_cmd.res     = ST_DUP_KEY;
                            n_state       = S_DONE;
                        end else if (i_stat.next_end) begin
                            n_state = S_APP1;
                        end else begin
                            o_cmd.walk_next = 1'b1;
                        end
                    end
                    default: begin
                        if (i_stat.next_tgt) begin
                            n_state = S_DELLINK;
                        end else if (i_stat.next_end) begin
                            n_state = S_DELFIN;
                        end else begin
                            o_cmd.walk_next = 1'b1;
                        end
                    end
                endcase
            end
            S_APP1: begin
                o_cmd.wr_next_tail = 1'b1;
                n_state            = S_APP2;
            end
            S_APP2: begin
                o_cmd.app_fin = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ST_OK;
                n_state       = S_DONE;
            end
            S_DELLINK: begin
                o_cmd.wr_next_del = 1'b1;
                n_state           = S_DELFIN;
            end
            S_DELFIN: begin
                o_cmd.del_fin = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ST_OK;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register frees up
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule
`default_nettype wire

### rtl/aigsh_checker.sv
`default_nettype none
module aigsh_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_status,
    input wire logic [9:0] o_match_id,
    input wire logic [10:0] o_entry_count
);
    import aigsh_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_match_id))
        else $error("stalled result changed");

    // Status is a defined code
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_BAD_ORDER)
        else $error("undefined status code");

    // Only a hit carries a match id
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_match_id == '0)
        else $error("match id on a non-hit");

    // Count stays within capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= 11'(NodesDefault))
        else $error("entry count above capacity");

endmodule

bind aig_structural_hash_table_core aigsh_checker u_aigsh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_match_id    (o_match_id),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
